// ===== rtl/intel_hex_record_parser_assert.svh =====
// assertion macros shared by the hex record parser modules
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

// property checked on every clock edge outside reset
`define IHEX_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ihex assertion failed");

// implication checked on every clock edge outside reset
`define IHEX_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ihex assertion failed");

`endif

// ===== rtl/ihex_pkg.sv =====
// types, codes and helpers for the hex record parser
package ihex_pkg;

   localparam int CH_W       = 8;
   localparam int ADDR_W     = 32;
   localparam int RSP_DATA_W = 144;

   localparam logic OP_CHAR   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic REG_WINDOW_ORIGIN = 1'b0;
   localparam logic REG_WINDOW_SIZE   = 1'b1;

   typedef enum logic [2:0] {
      PH_COLON  = 3'd0,
      PH_COUNT  = 3'd1,
      PH_OFFSET = 3'd2,
      PH_TYPE   = 3'd3,
      PH_DATA   = 3'd4,
      PH_UPPER  = 3'd5,
      PH_ENTRY  = 3'd6,
      PH_CHECK  = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_ERROR   = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_MALFORMED  = 2'd0,
      ERR_BAD_RECORD = 2'd1,
      ERR_CHECKSUM   = 2'd2
   } err_type;

   localparam logic [7:0] REC_DATA  = 8'h00;
   localparam logic [7:0] REC_EOF   = 8'h01;
   localparam logic [7:0] REC_UPPER = 8'h04;
   localparam logic [7:0] REC_ENTRY = 8'h05;

   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic [ADDR_W-1:0]   write_address;
      logic [7:0]          write_byte;
      err_type             error_code;
      logic [ADDR_W-1:0]   start_address;
      logic [ADDR_W-1:0]   used_origin;
      logic [ADDR_W-1:0]   used_size;
   } result_type;

   function automatic logic [3:0] digits_needed(input phase_type ph);
      logic [3:0] n;
      case (ph)
         PH_COUNT:  n = 4'd2;
         PH_OFFSET: n = 4'd4;
         PH_TYPE:   n = 4'd2;
         PH_DATA:   n = 4'd2;
         PH_UPPER:  n = 4'd4;
         PH_ENTRY:  n = 4'd8;
         PH_CHECK:  n = 4'd2;
         default:   n = 4'd0;
      endcase
      return n;
   endfunction

   // bit 4 flags a valid hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

// ===== rtl/ihex_core.sv =====
// record parser state and per-character result logic
`include "intel_hex_record_parser_assert.svh"

module ihex_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       op,
   input  logic [7:0]                 ch,
   input  logic [31:0]                window_origin,
   input  logic [31:0]                window_size,
   output ihex_pkg::result_type       res
);
   import ihex_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  digit_ff, digit_in;
   logic [31:0] field_ff, field_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] upper_ff, upper_in;
   logic [31:0] entry_ff, entry_in;
   logic [31:0] lowest_ff, lowest_in;
   logic [31:0] highest_ff, highest_in;
   logic        failed_ff, failed_in;
   err_type     code_ff, code_in;

   logic [4:0]  hexv;
   logic [31:0] fv;
   logic [3:0]  dc;
   logic [7:0]  newsum;
   logic [31:0] addr;
   logic [31:0] rel;
   logic        outside;
   logic        is_space;
   logic        fail_en;
   err_type     fail_code;

   assign hexv     = hex_digit(ch);
   assign fv       = {field_ff[27:0], hexv[3:0]};
   assign dc       = {1'b0, digit_ff} + 4'd1;
   assign newsum   = dc[0] ? sum_ff : sum_ff + fv[7:0];
   assign addr     = {upper_ff, offset_ff};
   assign rel      = addr - window_origin;
   assign outside  = (addr < window_origin) || (rel >= window_size);
   assign is_space = (ch == CH_SPACE) || (ch inside {[8'd9:8'd13]});

   always_comb begin
      phase_in   = phase_ff;
      digit_in   = digit_ff;
      field_in   = field_ff;
      left_in    = left_ff;
      offset_in  = offset_ff;
      sum_in     = sum_ff;
      upper_in   = upper_ff;
      entry_in   = entry_ff;
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      failed_in  = failed_ff;
      code_in    = code_ff;
      fail_en    = 1'b0;
      fail_code  = ERR_MALFORMED;
      res        = '0;
      if (step) begin
         if (op == OP_FINISH) begin
            res.valid = 1'b1;
            if (failed_ff) begin
               res.kind       = KIND_ERROR;
               res.error_code = code_ff;
            end else if (phase_ff != PH_COLON) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_MALFORMED;
            end else begin
               res.kind          = KIND_SUMMARY;
               res.start_address = entry_ff;
               if (lowest_ff > highest_ff) begin
                  res.used_origin = window_origin;
               end else begin
                  res.used_origin = lowest_ff;
                  res.used_size   = highest_ff - lowest_ff + 32'd1;
               end
            end
            phase_in   = PH_COLON;
            digit_in   = '0;
            field_in   = '0;
            left_in    = '0;
            offset_in  = '0;
            sum_in     = '0;
            upper_in   = '0;
            entry_in   = '0;
            lowest_in  = '1;
            highest_in = '0;
            failed_in  = 1'b0;
            code_in    = ERR_MALFORMED;
         end else if (!failed_ff) begin
            if (phase_ff == PH_COLON) begin
               if (ch == CH_COLON) begin
                  phase_in = PH_COUNT;
                  digit_in = '0;
                  field_in = '0;
                  sum_in   = '0;
               end else if (!is_space) begin
                  fail_en = 1'b1;
               end
            end else if (phase_ff == PH_DATA && digit_ff == 3'd0 && outside) begin
               fail_en   = 1'b1;
               fail_code = ERR_BAD_RECORD;
            end else if (!hexv[4]) begin
               fail_en = 1'b1;
            end else begin
               field_in = fv;
               digit_in = dc[2:0];
               sum_in   = newsum;
               if (dc >= digits_needed(phase_ff)) begin
                  field_in = '0;
                  digit_in = '0;
                  case (phase_ff)
                     PH_COUNT: begin
                        left_in  = fv[7:0];
                        phase_in = PH_OFFSET;
                     end
                     PH_OFFSET: begin
                        offset_in = fv[15:0];
                        phase_in  = PH_TYPE;
                     end
                     PH_TYPE: begin
                        case (fv[7:0])
                           REC_DATA:  phase_in = (left_ff != 8'd0) ? PH_DATA : PH_CHECK;
                           REC_EOF:   phase_in = PH_CHECK;
                           REC_UPPER: phase_in = PH_UPPER;
                           REC_ENTRY: phase_in = PH_ENTRY;
                           default: begin
                              fail_en   = 1'b1;
                              fail_code = ERR_BAD_RECORD;
                           end
                        endcase
                     end
                     PH_DATA: begin
                        if (addr > highest_ff) highest_in = addr;
                        if (addr < lowest_ff) lowest_in = addr;
                        res.valid         = 1'b1;
                        res.kind          = KIND_DATA;
                        res.write_address = addr;
                        res.write_byte    = fv[7:0];
                        offset_in         = offset_ff + 16'd1;
                        left_in           = left_ff - 8'd1;
                        if (left_ff == 8'd1) phase_in = PH_CHECK;
                     end
                     PH_UPPER: begin
                        upper_in = fv[15:0];
                        phase_in = PH_CHECK;
                     end
                     PH_ENTRY: begin
                        entry_in = fv;
                        phase_in = PH_CHECK;
                     end
                     PH_CHECK: begin
                        if (newsum != 8'd0) begin
                           fail_en   = 1'b1;
                           fail_code = ERR_CHECKSUM;
                        end else begin
                           phase_in = PH_COLON;
                        end
                     end
                     default: phase_in = PH_COLON;
                  endcase
               end
            end
            if (fail_en) begin
               failed_in      = 1'b1;
               code_in        = fail_code;
               res            = '0;
               res.valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = fail_code;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_COLON;
         digit_ff   <= '0;
         field_ff   <= '0;
         left_ff    <= '0;
         offset_ff  <= '0;
         sum_ff     <= '0;
         upper_ff   <= '0;
         entry_ff   <= '0;
         lowest_ff  <= '1;
         highest_ff <= '0;
         failed_ff  <= 1'b0;
         code_ff    <= ERR_MALFORMED;
      end else begin
         phase_ff   <= phase_in;
         digit_ff   <= digit_in;
         field_ff   <= field_in;
         left_ff    <= left_in;
         offset_ff  <= offset_in;
         sum_ff     <= sum_in;
         upper_ff   <= upper_in;
         entry_ff   <= entry_in;
         lowest_ff  <= lowest_in;
         highest_ff <= highest_in;
         failed_ff  <= failed_in;
         code_ff    <= code_in;
      end
   end

   `IHEX_ASSERT_IMPL(a_finish_clears, clock, reset, step && op,
      ##1 (phase_ff == PH_COLON && !failed_ff && lowest_ff == '1))
   `IHEX_ASSERT_IMPL(a_failed_silent, clock, reset, step && !op && failed_ff, !res.valid)
   `IHEX_ASSERT_IMPL(a_data_only_in_data, clock, reset,
      res.valid && res.kind == KIND_DATA, phase_ff == PH_DATA && digit_ff == 3'd1)

endmodule

// ===== rtl/intel_hex_record_parser.sv =====
// top level of the hex record parser: input word stage, result word stage, window registers
//
// req channel: one word per character; tuser is op (0 text character, 1 end of stream),
// tdata is the character. rsp channel: at most one word per request word, tuser is the
// kind (data byte, error report, finish summary), tdata carries the result fields.
// csr channel: index 0 writes window_origin, index 1 writes window_size; always ready.
// it must be written only while the parser is idle; the block itself does not enforce this.
// a request word is registered in the input stage and its result word in the result stage.
// throughput: one character per cycle while rsp is not stalled, set by the parser state update
// between the input stage and the result stage.
// a stalled rsp side holds the result word; the input stage then fills and req_tready
// drops until the result word is taken, with no word lost.
// reset (synchronous, active high) empties both stages, returns the parser to waiting for
// a record start and clears both window registers.
// an end-of-stream word reports the load and returns the parser to its reset state.
`include "intel_hex_record_parser_assert.svh"

module intel_hex_record_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,   // op
   input  logic [ihex_pkg::CH_W-1:0]         req_tdata,   // ch
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [1:0]                        rsp_tuser,   // kind
   // write_address, write_byte, error_code, start_address, used_origin, used_size
   output logic [ihex_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [ihex_pkg::ADDR_W-1:0]       csr_data
);
   import ihex_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic              in_op_ff;
   logic [CH_W-1:0]   in_ch_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;
   logic [ADDR_W-1:0] origin_ff, size_ff;
   logic              advance;
   logic              step;
   logic              req_fire;
   result_type        res;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? res.valid : rsp_valid_ff;

   ihex_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .op            (in_op_ff),
      .ch            (in_ch_ff),
      .window_origin (origin_ff),
      .window_size   (size_ff),
      .res           (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         origin_ff    <= '0;
         size_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_WINDOW_SIZE) size_ff <= csr_data;
            else origin_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff <= req_tuser;
         in_ch_ff <= req_tdata;
      end
      if (advance) rsp_ff <= res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {6'b0, rsp_ff.used_size, rsp_ff.used_origin, rsp_ff.start_address,
                        rsp_ff.error_code, rsp_ff.write_byte, rsp_ff.write_address};

   `IHEX_ASSERT_IMPL(a_input_held, clock, reset, in_valid_ff && !advance,
      ##1 (in_valid_ff && $stable(in_ch_ff) && $stable(in_op_ff)))
   `IHEX_ASSERT_IMPL(a_error_fields, clock, reset, rsp_tvalid && rsp_tuser == KIND_ERROR,
      rsp_tdata[39:0] == 40'd0 && rsp_tdata[137:42] == 96'd0)
   `IHEX_ASSERT(a_summary_from_finish, clock, reset,
      !(rsp_valid_in && advance && res.kind == KIND_SUMMARY) || in_op_ff)

endmodule

// ===== test/intel_hex_record_parser_tb.sv =====
// self-checking testbench for intel_hex_record_parser: hex record text in, predicted words checked
module intel_hex_record_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ihex_pkg::*;

   localparam int FLAW_NONE     = 0;
   localparam int FLAW_CHECKSUM = 1;
   localparam int FLAW_BAD_CHAR = 2;
   localparam int FLAW_TRUNCATE = 3;

   localparam int LATENCY_WAIT    = 4;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int WORDS_PER_PHASE = 110;

   localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

   class hex_load_scoreboard;
      logic [31:0] window_origin;
      logic [31:0] window_size;
      phase_type   phase;
      logic [3:0]  digit_count;
      logic [31:0] field_value;
      logic [7:0]  bytes_left;
      logic [7:0]  record_type;
      logic [15:0] record_offset;
      logic [7:0]  running_sum;
      logic [15:0] upper_address;
      logic [31:0] entry_address;
      logic [31:0] lowest_address;
      logic [31:0] highest_address;
      bit          failed;
      err_type     failure_code;
      result_type  expected_q[$];
      int          mismatches;

      function new();
         window_origin = '0;
         window_size = '0;
         mismatches = 0;
         clear_load();
      endfunction

      function void clear_load();
         phase = PH_COLON;
         digit_count = '0;
         field_value = '0;
         bytes_left = '0;
         record_type = '0;
         record_offset = '0;
         running_sum = '0;
         upper_address = '0;
         entry_address = '0;
         lowest_address = '1;
         highest_address = '0;
         failed = 1'b0;
         failure_code = ERR_MALFORMED;
      endfunction

      function void push_error(err_type code);
         result_type r;
         failed = 1'b1;
         failure_code = code;
         r = '0;
         r.valid = 1'b1;
         r.kind = KIND_ERROR;
         r.error_code = code;
         expected_q.push_back(r);
      endfunction

      function void note_input(logic op, logic [7:0] ch);
         result_type  r;
         logic [31:0] addr;
         logic [31:0] v;
         logic [3:0]  nib;
         logic [3:0]  need;
         logic        is_digit;
         if (op == OP_FINISH) begin
            r = '0;
            r.valid = 1'b1;
            if (failed) begin
               r.kind = KIND_ERROR;
               r.error_code = failure_code;
            end else if (phase != PH_COLON) begin
               r.kind = KIND_ERROR;
               r.error_code = ERR_MALFORMED;
            end else begin
               r.kind = KIND_SUMMARY;
               r.start_address = entry_address;
               if (lowest_address > highest_address) begin
                  r.used_origin = window_origin;
                  r.used_size = '0;
               end else begin
                  r.used_origin = lowest_address;
                  r.used_size = highest_address - lowest_address + 32'd1;
               end
            end
            expected_q.push_back(r);
            clear_load();
            return;
         end
         if (failed) return;
         if (phase == PH_COLON) begin
            if (ch == CH_COLON) begin
               phase = PH_COUNT;
               digit_count = '0;
               field_value = '0;
               running_sum = '0;
            end else if (!(ch == CH_SPACE || (ch >= 8'h09 && ch <= 8'h0d))) begin
               push_error(ERR_MALFORMED);
            end
            return;
         end
         addr = {upper_address, record_offset};
         if (phase == PH_DATA && digit_count == 0) begin
            if (addr < window_origin || addr - window_origin >= window_size) begin
               push_error(ERR_BAD_RECORD);
               return;
            end
         end
         is_digit = 1'b1;
         nib = '0;
         if (ch >= "0" && ch <= "9") nib = 4'(ch - "0");
         else if (ch >= "A" && ch <= "F") nib = 4'(ch - "A" + 8'd10);
         else if (ch >= "a" && ch <= "f") nib = 4'(ch - "a" + 8'd10);
         else is_digit = 1'b0;
         if (!is_digit) begin
            push_error(ERR_MALFORMED);
            return;
         end
         field_value = {field_value[27:0], nib};
         digit_count = digit_count + 4'd1;
         if (!digit_count[0]) running_sum = running_sum + field_value[7:0];
         case (phase)
            PH_OFFSET, PH_UPPER: need = 4'd4;
            PH_ENTRY:            need = 4'd8;
            default:             need = 4'd2;
         endcase
         if (digit_count < need) return;
         v = field_value;
         digit_count = '0;
         field_value = '0;
         case (phase)
            PH_COUNT: begin
               bytes_left = v[7:0];
               phase = PH_OFFSET;
            end
            PH_OFFSET: begin
               record_offset = v[15:0];
               phase = PH_TYPE;
            end
            PH_TYPE: begin
               record_type = v[7:0];
               if (record_type == REC_DATA) begin
                  if (bytes_left != 0) phase = PH_DATA;
                  else phase = PH_CHECK;
               end else if (record_type == REC_EOF) begin
                  phase = PH_CHECK;
               end else if (record_type == REC_UPPER) begin
                  phase = PH_UPPER;
               end else if (record_type == REC_ENTRY) begin
                  phase = PH_ENTRY;
               end else begin
                  push_error(ERR_BAD_RECORD);
               end
            end
            PH_DATA: begin
               if (addr > highest_address) highest_address = addr;
               if (addr < lowest_address) lowest_address = addr;
               r = '0;
               r.valid = 1'b1;
               r.kind = KIND_DATA;
               r.write_address = addr;
               r.write_byte = v[7:0];
               expected_q.push_back(r);
               record_offset = record_offset + 16'd1;
               bytes_left = bytes_left - 8'd1;
               if (bytes_left == 0) phase = PH_CHECK;
            end
            PH_UPPER: begin
               upper_address = v[15:0];
               phase = PH_CHECK;
            end
            PH_ENTRY: begin
               entry_address = v;
               phase = PH_CHECK;
            end
            default: begin
               if (running_sum != 0) push_error(ERR_CHECKSUM);
               else phase = PH_COLON;
            end
         endcase
      endfunction

      task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("mismatch in %s: got %h, expected %h", field, got, want);
      endtask

      task check_result(kind_type kind, logic [RSP_DATA_W-1:0] data);
         result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("kind of unexpected word", 32'(kind), 32'd0);
            return;
         end
         want = expected_q.pop_front();
         if (kind !== want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
         if (data[31:0] !== want.write_address)
            report_mismatch("write_address", data[31:0], want.write_address);
         if (data[39:32] !== want.write_byte)
            report_mismatch("write_byte", 32'(data[39:32]), 32'(want.write_byte));
         if (data[41:40] !== want.error_code)
            report_mismatch("error_code", 32'(data[41:40]), 32'(want.error_code));
         if (data[73:42] !== want.start_address)
            report_mismatch("start_address", data[73:42], want.start_address);
         if (data[105:74] !== want.used_origin)
            report_mismatch("used_origin", data[105:74], want.used_origin);
         if (data[137:106] !== want.used_size)
            report_mismatch("used_size", data[137:106], want.used_size);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = 1'b0;
   logic [CH_W-1:0]       req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [1:0]            rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = 1'b0;
   logic [ADDR_W-1:0]     csr_data = '0;

   hex_load_scoreboard sb;
   bit sender_gaps = 1'b1;
   bit rsp_stalls = 1'b1;
   bit hold_off_req = 1'b0;
   int words_sent = 0;
   int idle_cycles = 0;

   intel_hex_record_parser dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return "0" + 8'(nib);
      if ($urandom_range(0, 1) == 0) return "A" + 8'(nib) - 8'd10;
      return "a" + 8'(nib) - 8'd10;
   endfunction

   // word and handshake monitor, watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(kind_type'(rsp_tuser), rsp_tdata);
         if (req_tvalid && req_tready) sb.note_input(req_tuser, req_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // result receiver
   always begin
      @(negedge clock);
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         rsp_tready <= 1'b0;
         repeat (HOLD_OFF_CYCLES) @(negedge clock);
      end else if (rsp_stalls && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         repeat (pick_gap()) @(negedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_word(input logic op, input logic [7:0] ch);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= ch;
      do @(posedge clock); while (req_tready !== 1'b1);
      words_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (index == REG_WINDOW_ORIGIN) sb.window_origin = value;
      else sb.window_size = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_window(input logic [31:0] origin, input logic [31:0] size);
      wait_for_drain();
      write_reg(REG_WINDOW_ORIGIN, origin);
      write_reg(REG_WINDOW_SIZE, size);
   endtask

   task automatic send_record(input logic [7:0] rtype, input logic [7:0] count,
         input logic [15:0] offset, input logic [7:0] payload[$], input int flaw);
      logic [7:0] bytes[$];
      logic [7:0] text[$];
      logic [7:0] sum;
      logic [7:0] c;
      int colon_at;
      int cut;
      bytes = {count, offset[15:8], offset[7:0], rtype};
      foreach (payload[i]) bytes.push_back(payload[i]);
      sum = '0;
      foreach (bytes[i]) sum = sum + bytes[i];
      if (flaw == FLAW_CHECKSUM) sum = sum + 8'($urandom_range(1, 255));
      bytes.push_back(8'd0 - sum);
      repeat ($urandom_range(0, 2)) text.push_back(BLANKS[$urandom_range(0, 5)]);
      colon_at = text.size();
      text.push_back(CH_COLON);
      foreach (bytes[i]) begin
         text.push_back(hex_char(bytes[i][7:4]));
         text.push_back(hex_char(bytes[i][3:0]));
      end
      cut = $urandom_range(colon_at + 1, text.size() - 1);
      if (flaw == FLAW_BAD_CHAR) begin
         do c = 8'($urandom_range(0, 255));
         while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
         text[cut] = c;
      end else if (flaw == FLAW_TRUNCATE) begin
         text = text[0:cut-1];
      end
      foreach (text[i]) send_word(OP_CHAR, text[i]);
   endtask

   task automatic send_data(input logic [15:0] offset, input int count, input int flaw);
      logic [7:0] pl[$];
      repeat (count) begin
         case ($urandom_range(0, 3))
            0:       pl.push_back(8'h00);
            1:       pl.push_back(8'hff);
            default: pl.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      send_record(REC_DATA, 8'(count), offset, pl, flaw);
   endtask

   task automatic send_upper(input logic [15:0] upper, input int flaw);
      logic [7:0] pl[$];
      pl = {upper[15:8], upper[7:0]};
      send_record(REC_UPPER, 8'd2, 16'($urandom), pl, flaw);
   endtask

   task automatic send_entry(input logic [31:0] entry, input int flaw);
      logic [7:0] pl[$];
      pl = {entry[31:24], entry[23:16], entry[15:8], entry[7:0]};
      send_record(REC_ENTRY, 8'd4, 16'($urandom), pl, flaw);
   endtask

   task automatic send_other(input logic [7:0] rtype, input int flaw);
      logic [7:0] pl[$];
      repeat ($urandom_range(0, 3)) pl.push_back(8'($urandom_range(0, 255)));
      send_record(rtype, 8'($urandom_range(0, 255)), 16'($urandom), pl, flaw);
   endtask

   task automatic random_load(input logic [31:0] origin, input logic [31:0] size);
      logic [15:0] cur_upper;
      logic [31:0] addr;
      logic [7:0]  rtype;
      int roll;
      int flaw;
      int count;
      cur_upper = '0;
      repeat ($urandom_range(1, 6)) begin
         flaw = FLAW_NONE;
         if ($urandom_range(0, 99) < 8) flaw = $urandom_range(FLAW_CHECKSUM, FLAW_TRUNCATE);
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            send_word(OP_CHAR, 8'($urandom_range(0, 255)));
         end else if (roll < 62) begin
            case ($urandom_range(0, 3))
               0:       addr = origin;
               1:       addr = origin + size - 32'($urandom_range(0, 8));
               2:       addr = origin + ((size == 0) ? 32'd0 : 32'($urandom) % size);
               default: addr = $urandom;
            endcase
            if (addr[31:16] != cur_upper || $urandom_range(0, 7) == 0) begin
               send_upper(addr[31:16], FLAW_NONE);
               cur_upper = addr[31:16];
            end
            roll = $urandom_range(0, 99);
            if (roll < 5) count = 0;
            else if (roll < 90) count = $urandom_range(1, 8);
            else count = $urandom_range(9, 40);
            send_data(addr[15:0], count, flaw);
         end else if (roll < 72) begin
            cur_upper = 16'($urandom);
            send_upper(cur_upper, flaw);
         end else if (roll < 80) begin
            send_entry($urandom, flaw);
         end else if (roll < 90) begin
            send_other(REC_EOF, flaw);
         end else begin
            do rtype = 8'($urandom_range(0, 255));
            while (rtype == REC_DATA || rtype == REC_EOF || rtype == REC_UPPER ||
                   rtype == REC_ENTRY);
            send_other(rtype, flaw);
         end
      end
      send_word(OP_FINISH, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      logic [31:0] origin;
      logic [31:0] size;
      int start;
      sb = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // empty load, then a data word outside the zero-size window
      send_word(OP_FINISH, 8'h00);
      send_data(16'h0000, 1, FLAW_NONE);
      send_word(OP_FINISH, 8'hff);

      write_window(32'h0000_0000, 32'hffff_ffff);
      send_data(16'hffff, 2, FLAW_NONE);
      send_upper(16'h1234, FLAW_NONE);
      send_entry(32'hdead_beef, FLAW_NONE);
      send_data(16'h0010, 1, FLAW_NONE);
      send_data(16'h0020, 0, FLAW_NONE);
      send_other(REC_EOF, FLAW_NONE);
      send_word(OP_FINISH, 8'h80);
      // unknown record type, later text ignored
      send_other(8'h02, FLAW_NONE);
      send_data(16'h0000, 1, FLAW_NONE);
      send_word(OP_FINISH, 8'h7f);
      send_data(16'h0040, 2, FLAW_CHECKSUM);
      send_word(OP_FINISH, 8'h01);
      send_data(16'h0050, 3, FLAW_BAD_CHAR);
      send_word(OP_FINISH, 8'h00);
      send_word(OP_CHAR, "x");
      send_word(OP_FINISH, 8'h00);
      // finish inside a record
      send_data(16'h0060, 4, FLAW_TRUNCATE);
      send_word(OP_FINISH, 8'h00);

      write_window(32'h0000_1000, 32'h0000_0010);
      send_data(16'h0fff, 1, FLAW_NONE);
      send_word(OP_FINISH, 8'h00);
      send_data(16'h100e, 3, FLAW_NONE);
      send_word(OP_FINISH, 8'h00);

      write_window(32'hffff_ffff, 32'h0000_0001);
      send_upper(16'hffff, FLAW_NONE);
      send_data(16'hffff, 1, FLAW_NONE);
      send_word(OP_FINISH, 8'h00);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       begin origin = 32'h0000_0000; size = 32'hffff_ffff; end
            1:       begin origin = $urandom; size = $urandom_range(1, 32'h400); end
            2:       begin origin = $urandom & 32'hffff_0000; size = 32'h0003_0000; end
            3:       begin origin = 32'h8000_0000; size = 32'h0000_0000; end
            4:       begin origin = 32'hffff_0000; size = 32'h0000_ffff; end
            5:       begin origin = $urandom; size = 32'hffff_ffff; end
            6:       begin origin = 32'h0000_0000; size = 32'h0000_0040; end
            default: begin origin = $urandom; size = $urandom; end
         endcase
         write_window(origin, size);
         sender_gaps = (ph % 3 != 0);
         rsp_stalls = (ph % 3 != 1);
         if (ph == 0) begin
            // receiver stalls while a long data record keeps coming
            hold_off_req = 1'b1;
            send_upper(16'h0000, FLAW_NONE);
            send_data(16'h0100, 40, FLAW_NONE);
            send_word(OP_FINISH, 8'h00);
         end
         start = words_sent;
         while (words_sent - start < WORDS_PER_PHASE) random_load(origin, size);
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
